@@ hw/rtl/sparse_weighted_variance_assert.svh @@
// Assertion macros for the weighted variance block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef SPARSE_WEIGHTED_VARIANCE_ASSERT_SVH
`define SPARSE_WEIGHTED_VARIANCE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SWV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SWV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SWV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define SWV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/swv_pkg.sv @@
// Package for the weighted variance block: field widths, action codes,
// controller states and the command/status structs. No dependencies.
package swv_pkg;

    localparam int unsigned W_ROW     = 12;
    localparam int unsigned W_WEIGHT  = 32;
    localparam int unsigned W_DATA    = 32;
    localparam int unsigned W_TOTAL   = 44;
    localparam int unsigned W_ACC     = 64;
    localparam int unsigned W_PROD    = 108;
    localparam int unsigned W_VAR     = 48;
    localparam int unsigned DIV_STEPS = 80;
    localparam int unsigned W_DCNT    = 7;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_ENTRY = 2'd1;
    localparam logic [1:0] ACT_EMPTY = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_WR,
        S_ESQ,
        S_FSQ,
        S_SQW,
        S_P0,
        S_P1,
        S_P2,
        S_P3,
        S_P4,
        S_ADD,
        S_DSTART,
        S_DIV,
        S_EMIT
    } t_state;

    typedef enum logic [2:0] {
        MUL_DEV_SQ,
        MUL_MEAN_SQ,
        MUL_LL,
        MUL_LH,
        MUL_HL,
        MUL_HH
    } t_mul_sel;

    typedef enum logic [1:0] {
        A_HOLD,
        A_WEIGHT,
        A_REMAIN
    } t_a_sel;

    typedef enum logic [1:0] {
        PROD_HOLD,
        PROD_LOAD,
        PROD_ADD32,
        PROD_ADD64
    } t_prod_op;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_a_sel   a_sel;
        t_prod_op prod_op;
        logic     sq_load;
        logic     acc_add;
        logic     fin_add;
        logic     wt_update;
        logic     clr_step;
        logic     div_start;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic total_zero;
        logic out_free;
    } t_stat;

endpackage

@@ hw/rtl/swv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swv_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/swv_div.sv @@
// Restoring divider, one quotient bit per cycle: floor(dividend * 2^16 / divisor),
// saturated to 48 bits. Depends on swv_pkg and the assertion header.
`include "sparse_weighted_variance_assert.svh"
module swv_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [swv_pkg::W_ACC-1:0]    i_dividend,
    input  logic [swv_pkg::W_TOTAL-1:0]  i_divisor,
    output logic                         o_done,
    output logic [swv_pkg::W_VAR-1:0]    o_quotient,
    output logic                         o_over
);
    import swv_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [W_DCNT-1:0]   r_cnt;
    logic [W_ACC-1:0]    r_dvd;
    logic [W_TOTAL-1:0]  r_dvs;
    logic [W_TOTAL-1:0]  r_rem;
    logic [W_VAR-1:0]    r_q;
    logic                r_over;

    logic [W_TOTAL:0]    rem_sh;
    logic                ge;
    logic [W_TOTAL:0]    rem_sub;
    logic [W_TOTAL-1:0]  n_rem;

    // dividend bits go in MSB first; zeros shift in behind them for the x2^16
    assign rem_sh  = {r_rem, r_dvd[W_ACC-1]};
    assign ge      = (rem_sh >= {1'b0, r_dvs});
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign n_rem   = ge ? rem_sub[W_TOTAL-1:0] : rem_sh[W_TOTAL-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && (r_cnt == W_DCNT'(DIV_STEPS - 1))) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= '0;
            r_dvd  <= i_dividend;
            r_dvs  <= i_divisor;
            r_rem  <= '0;
            r_q    <= '0;
            r_over <= 1'b0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt + W_DCNT'(1);
            r_dvd  <= {r_dvd[W_ACC-2:0], 1'b0};
            r_rem  <= n_rem;
            r_q    <= {r_q[W_VAR-2:0], ge};
            r_over <= r_over | r_q[W_VAR-1];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_over ? '1 : r_q;
    assign o_over     = r_over;

    `SWV_ASSERT_NXT(a_div_start_busy, i_clk, i_rst_n, i_start, r_busy && !r_done, "divider did not start")
    `SWV_ASSERT_IMP(a_div_done_idle, i_clk, i_rst_n, r_done, !r_busy, "divider done while busy")
    `SWV_ASSERT_IMP(a_div_rem_bound, i_clk, i_rst_n, r_busy, r_rem < r_dvs, "remainder not below divisor")

endmodule

@@ hw/rtl/swv_dp.sv @@
// Datapath: weight table, running totals, shared 32x32 multiplier with
// partial-product accumulator, divider and output register. Depends on swv_pkg,
// swv_ram, swv_div and the assertion header.
`include "sparse_weighted_variance_assert.svh"
module swv_dp #(
    parameter int unsigned ROWS = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic [swv_pkg::W_ROW-1:0]          i_row_index,
    input  logic [swv_pkg::W_WEIGHT-1:0]       i_weight_value,
    input  logic signed [swv_pkg::W_DATA-1:0]  i_entry_value,
    input  logic signed [swv_pkg::W_DATA-1:0]  i_column_mean,
    input  swv_pkg::t_cmd                      i_cmd,
    output swv_pkg::t_stat                     o_stat,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [swv_pkg::W_VAR-1:0]          o_variance,
    output logic                               o_weight_sum_zero,
    output logic                               o_saturated
);
    import swv_pkg::*;

    localparam int unsigned AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned IW       = (AW > W_ROW) ? AW : W_ROW;
    localparam logic [31:0] ROWS_LIM = 32'(ROWS);
    localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

    // item fields held from acceptance
    logic [AW-1:0]        r_addr;
    logic                 r_in_range;
    logic [W_WEIGHT-1:0]  r_wval;
    logic [W_DATA-1:0]    r_dev_abs;
    logic [W_DATA-1:0]    r_mean_abs;

    // running state
    logic [W_TOTAL-1:0]   r_total;
    logic [W_ACC-1:0]     r_acc;
    logic [W_TOTAL-1:0]   r_nzw;
    logic                 r_sat;
    logic [AW-1:0]        r_clr;

    // multiply path
    logic [W_TOTAL-1:0]   r_a;
    logic [W_ACC-1:0]     r_sq;
    logic [W_ACC-1:0]     r_mp;
    logic [W_PROD-1:0]    r_prod;

    // output register
    logic                 r_out_valid;
    logic [W_VAR-1:0]     r_variance;
    logic                 r_wsz;
    logic                 r_sat_out;

    logic [IW-1:0]        row_ext;
    logic                 in_range;
    logic signed [W_DATA:0] dev;
    logic [W_DATA:0]      dev_mag;
    logic [W_DATA:0]      mean_mag;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [W_WEIGHT-1:0]  ram_wdata;
    logic [W_WEIGHT-1:0]  ram_rdata;

    logic [W_TOTAL-1:0]   n_total;
    logic [W_DATA-1:0]    mul_x;
    logic [W_DATA-1:0]    mul_y;
    logic [W_DATA-1:0]    a_hi;
    logic [W_ACC-1:0]     n_mp;
    logic [W_PROD-1:0]    n_prod;
    logic                 prod_sat;
    logic [W_ACC-1:0]     term;
    logic [W_ACC:0]       acc_sum;
    logic [W_ACC-1:0]     n_acc;
    logic                 add_flag;
    logic [W_TOTAL:0]     nzw_sum;
    logic [W_TOTAL-1:0]   n_nzw;
    logic [W_TOTAL-1:0]   remaining;
    logic                 total_zero;
    logic                 out_free;

    logic                 div_done;
    logic [W_VAR-1:0]     div_q;
    logic                 div_over;

    assign row_ext  = IW'(i_row_index);
    assign in_range = (32'(i_row_index) < ROWS_LIM);
    assign dev      = {i_entry_value[W_DATA-1], i_entry_value}
                    - {i_column_mean[W_DATA-1], i_column_mean};
    assign dev_mag  = dev[W_DATA] ? (W_DATA + 1)'(-dev) : (W_DATA + 1)'(dev);
    assign mean_mag = i_column_mean[W_DATA-1]
                    ? (W_DATA + 1)'(-{i_column_mean[W_DATA-1], i_column_mean})
                    : (W_DATA + 1)'({1'b0, i_column_mean});

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_addr     <= row_ext[AW-1:0];
            r_in_range <= in_range;
            r_wval     <= i_weight_value;
            r_dev_abs  <= dev_mag[W_DATA-1:0];
            r_mean_abs <= mean_mag[W_DATA-1:0];
        end
    end

    // weight table; the sweep after reset writes zeros
    assign ram_we    = i_cmd.clr_step | (i_cmd.wt_update & r_in_range);
    assign ram_waddr = i_cmd.clr_step ? r_clr : r_addr;
    assign ram_wdata = i_cmd.clr_step ? '0 : r_wval;

    swv_ram #(
        .WIDTH (W_WEIGHT),
        .DEPTH (ROWS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_accept),
        .i_raddr (row_ext[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step && (r_clr != LAST_ROW)) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    // reload replaces the old weight, total moves by the difference (mod 2^44)
    assign n_total = r_total - W_TOTAL'(ram_rdata) + W_TOTAL'(r_wval);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (i_cmd.wt_update && r_in_range) begin
            r_total <= n_total;
        end
    end

    assign remaining = (r_total > r_nzw) ? (r_total - r_nzw) : '0;
    assign a_hi      = W_DATA'(r_a[W_TOTAL-1:W_DATA]);

    always_comb begin
        mul_x = '0;
        mul_y = '0;
        unique case (i_cmd.mul_sel)
            MUL_DEV_SQ: begin
                mul_x = r_dev_abs;
                mul_y = r_dev_abs;
            end
            MUL_MEAN_SQ: begin
                mul_x = r_mean_abs;
                mul_y = r_mean_abs;
            end
            MUL_LL: begin
                mul_x = r_a[W_DATA-1:0];
                mul_y = r_sq[W_DATA-1:0];
            end
            MUL_LH: begin
                mul_x = r_a[W_DATA-1:0];
                mul_y = r_sq[W_ACC-1:W_DATA];
            end
            MUL_HL: begin
                mul_x = a_hi;
                mul_y = r_sq[W_DATA-1:0];
            end
            MUL_HH: begin
                mul_x = a_hi;
                mul_y = r_sq[W_ACC-1:W_DATA];
            end
            default: begin
                mul_x = '0;
                mul_y = '0;
            end
        endcase
    end

    assign n_mp = W_ACC'(mul_x) * W_ACC'(mul_y);

    always_comb begin
        case (i_cmd.prod_op)
            PROD_LOAD:  n_prod = W_PROD'(r_mp);
            PROD_ADD32: n_prod = r_prod + (W_PROD'(r_mp) << W_DATA);
            PROD_ADD64: n_prod = r_prod + (W_PROD'(r_mp) << W_ACC);
            default:    n_prod = r_prod;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_mp   <= n_mp;
        r_prod <= n_prod;
        if (i_cmd.sq_load) begin
            r_sq <= r_mp;
        end
        case (i_cmd.a_sel)
            A_WEIGHT: r_a <= r_in_range ? W_TOTAL'(ram_rdata) : '0;
            A_REMAIN: r_a <= remaining;
            default:  r_a <= r_a;
        endcase
    end

    // product / 2^32 with saturation, then saturating add into the accumulator
    assign prod_sat = |r_prod[W_PROD-1:W_ACC+W_DATA];
    assign term     = prod_sat ? '1 : r_prod[W_ACC+W_DATA-1:W_DATA];
    assign acc_sum  = {1'b0, r_acc} + {1'b0, term};
    assign n_acc    = acc_sum[W_ACC] ? '1 : acc_sum[W_ACC-1:0];
    assign add_flag = prod_sat | acc_sum[W_ACC];
    assign nzw_sum  = {1'b0, r_nzw} + {1'b0, r_a};
    assign n_nzw    = nzw_sum[W_TOTAL] ? '1 : nzw_sum[W_TOTAL-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_nzw <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.emit) begin
            r_acc <= '0;
            r_nzw <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.acc_add) begin
            r_acc <= n_acc;
            r_nzw <= n_nzw;
            r_sat <= r_sat | add_flag;
        end else if (i_cmd.fin_add) begin
            r_acc <= n_acc;
            r_sat <= r_sat | add_flag;
        end
    end

    swv_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_acc),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_quotient (div_q),
        .o_over     (div_over)
    );

    assign total_zero = (r_total == '0);
    assign out_free   = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_variance <= total_zero ? '0 : div_q;
            r_wsz      <= total_zero;
            r_sat_out  <= r_sat | (!total_zero & div_over);
        end
    end

    assign o_stat.clr_last   = (r_clr == LAST_ROW);
    assign o_stat.div_done   = div_done;
    assign o_stat.total_zero = total_zero;
    assign o_stat.out_free   = out_free;

    assign o_out_valid       = r_out_valid;
    assign o_variance        = r_variance;
    assign o_weight_sum_zero = r_wsz;
    assign o_saturated       = r_sat_out;

    `SWV_ASSERT_NXT(a_dp_emit_clears, i_clk, i_rst_n, i_cmd.emit, (r_acc == '0) && (r_nzw == '0) && !r_sat, "column state not cleared")
    `SWV_ASSERT_IMP(a_dp_no_accept_clear, i_clk, i_rst_n, i_cmd.clr_step, !i_accept, "transaction taken during table clear")
    `SWV_ASSERT_NXT(a_dp_nzw_no_wrap, i_clk, i_rst_n, i_cmd.acc_add, r_nzw >= $past(r_nzw), "nonzero weight wrapped")

endmodule

@@ hw/rtl/swv_ctrl.sv @@
// Controller state machine: sequences table clear, weight loads, the
// multiply-accumulate steps, the division and result hand-off.
// Depends on swv_pkg and the assertion header.
`include "sparse_weighted_variance_assert.svh"
module swv_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_action,
    input  logic           i_last_entry,
    input  swv_pkg::t_stat i_stat,
    output logic           o_in_ready,
    output swv_pkg::t_cmd  o_cmd
);
    import swv_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_last;
    logic   n_last;
    logic   r_fin;
    logic   n_fin;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_last  <= 1'b0;
            r_fin   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last  <= n_last;
            r_fin   <= n_fin;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_last      = r_last;
        n_fin       = r_fin;
        cmd         = '0;
        cmd.mul_sel = MUL_LL;
        cmd.a_sel   = A_HOLD;
        cmd.prod_op = PROD_HOLD;
        o_in_ready  = (r_state == S_IDLE);
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_last = i_last_entry;
                    unique case (i_action)
                        ACT_LOAD:  n_state = S_LD_WR;
                        ACT_ENTRY: n_state = S_ESQ;
                        ACT_EMPTY: begin
                            n_state = S_FSQ;
                            n_fin   = 1'b1;
                        end
                        default:   n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_WR: begin
                cmd.wt_update = 1'b1;
                n_state       = S_IDLE;
            end
            S_ESQ: begin
                cmd.mul_sel = MUL_DEV_SQ;
                cmd.a_sel   = A_WEIGHT;
                n_state     = S_SQW;
            end
            S_FSQ: begin
                cmd.mul_sel = MUL_MEAN_SQ;
                cmd.a_sel   = A_REMAIN;
                n_state     = S_SQW;
            end
            S_SQW: begin
                cmd.sq_load = 1'b1;
                n_state     = S_P0;
            end
            S_P0: begin
                cmd.mul_sel = MUL_LL;
                n_state     = S_P1;
            end
            S_P1: begin
                cmd.mul_sel = MUL_LH;
                cmd.prod_op = PROD_LOAD;
                n_state     = S_P2;
            end
            S_P2: begin
                cmd.mul_sel = MUL_HL;
                cmd.prod_op = PROD_ADD32;
                n_state     = S_P3;
            end
            S_P3: begin
                cmd.mul_sel = MUL_HH;
                cmd.prod_op = PROD_ADD32;
                n_state     = S_P4;
            end
            S_P4: begin
                cmd.prod_op = PROD_ADD64;
                n_state     = S_ADD;
            end
            S_ADD: begin
                if (r_fin) begin
                    cmd.fin_add = 1'b1;
                    n_state     = S_DSTART;
                end else begin
                    cmd.acc_add = 1'b1;
                    if (r_last) begin
                        n_state = S_FSQ;
                        n_fin   = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DSTART: begin
                // zero total skips the divide, result is forced to zero
                if (i_stat.total_zero) begin
                    n_state = S_EMIT;
                end else begin
                    cmd.div_start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    n_fin    = 1'b0;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd = cmd;

    `SWV_ASSERT_IMP(a_ctl_emit_free, i_clk, i_rst_n, cmd.emit, i_stat.out_free, "result overwrites pending transaction")
    `SWV_ASSERT_IMP(a_ctl_div_nonzero, i_clk, i_rst_n, cmd.div_start, !i_stat.total_zero, "divide by zero total")
    `SWV_ASSERT_IMP(a_ctl_idle_no_fin, i_clk, i_rst_n, r_state == S_IDLE, !r_fin, "finish pending in idle")

endmodule

@@ hw/rtl/sparse_weighted_variance.sv @@
// Top level of the sparse weighted column variance block.
// Depends on swv_pkg, swv_ctrl and swv_dp (with swv_ram, swv_div below it).
//
//  channel | dir | payload                                          | handshake
//  --------+-----+--------------------------------------------------+------------------------
//  in      | in  | action, row_index, weight_value, entry_value,    | i_in_valid / o_in_ready
//          |     | column_mean, last_entry                          |
//  out     | out | variance, weight_sum_zero, saturated             | o_out_valid / i_out_ready
//
// A weight load is a single table write; a nonzero entry runs on the single shared
// 32x32 multiplier (square, then four partial products).
// Finishing a column adds a mean-square multiply pass and the bit-serial divider.
// After reset the weight table is swept to zero row by row; no transaction
// is taken until the sweep ends.
// Loads and entries pass a waiting result; the next finish stalls and takes no input.
module sparse_weighted_variance #(
    parameter int unsigned ROWS = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_action,
    input  logic [swv_pkg::W_ROW-1:0]          i_row_index,
    input  logic [swv_pkg::W_WEIGHT-1:0]       i_weight_value,
    input  logic signed [swv_pkg::W_DATA-1:0]  i_entry_value,
    input  logic signed [swv_pkg::W_DATA-1:0]  i_column_mean,
    input  logic                               i_last_entry,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [swv_pkg::W_VAR-1:0]          o_variance,
    output logic                               o_weight_sum_zero,
    output logic                               o_saturated
);
    import swv_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;
    logic  accept;

    assign accept     = i_in_valid & in_ready;
    assign o_in_ready = in_ready;

    swv_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_action     (i_action),
        .i_last_entry (i_last_entry),
        .i_stat       (stat),
        .o_in_ready   (in_ready),
        .o_cmd        (cmd)
    );

    swv_dp #(
        .ROWS (ROWS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_row_index       (i_row_index),
        .i_weight_value    (i_weight_value),
        .i_entry_value     (i_entry_value),
        .i_column_mean     (i_column_mean),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_variance        (o_variance),
        .o_weight_sum_zero (o_weight_sum_zero),
        .o_saturated       (o_saturated)
    );

endmodule
